// ----- src/two_button_gesture_recognizer_core_assert.svh -----
// Assertion macros for the checker file.
`ifndef TWO_BUTTON_GESTURE_RECOGNIZER_CORE_ASSERT_SVH
`define TWO_BUTTON_GESTURE_RECOGNIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TBGR_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TBGR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/tbgr_pkg.sv -----
`default_nettype none

package tbgr_pkg;

   localparam int TIME_WIDTH_DEF = 32;
   localparam int NOW_WIDTH      = 32;
   localparam int CFG_WIDTH      = 16;
   localparam int CSR_IDX_WIDTH  = 3;

   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_FLUSH   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [2:0] G_NONE   = 3'd0;
   localparam logic [2:0] G_TAP_L  = 3'd1;
   localparam logic [2:0] G_TAP_R  = 3'd2;
   localparam logic [2:0] G_HOLD_L = 3'd3;
   localparam logic [2:0] G_HOLD_R = 3'd4;
   localparam logic [2:0] G_CHORD  = 3'd5;
   localparam logic [2:0] G_LONG   = 3'd6;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_DEBOUNCE     = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_HOLD         = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_REPEAT_START = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_REPEAT_PER   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LONG_CHORD   = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_CHORD_SKEW   = 3'd5;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST     = 16'd25;
   localparam logic [CFG_WIDTH-1:0] HOLD_RST         = 16'd500;
   localparam logic [CFG_WIDTH-1:0] REPEAT_START_RST = 16'd600;
   localparam logic [CFG_WIDTH-1:0] REPEAT_PER_RST   = 16'd100;
   localparam logic [CFG_WIDTH-1:0] LONG_CHORD_RST   = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] CHORD_SKEW_RST   = 16'd80;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_time;
      logic [CFG_WIDTH-1:0] hold_time;
      logic [CFG_WIDTH-1:0] repeat_start_time;
      logic [CFG_WIDTH-1:0] repeat_period;
      logic [CFG_WIDTH-1:0] long_chord_time;
      logic [CFG_WIDTH-1:0] chord_skew_limit;
   } cfg_type;

   typedef struct packed {
      logic       two_results;
      logic [2:0] gesture0;
      logic [2:0] gesture1;
      logic [1:0] debounced_bits;
      logic [1:0] press_edges;
   } step_result_type;

   typedef struct packed {
      logic [2:0] gesture;
      logic [1:0] debounced_bits;
      logic [1:0] press_edges;
      logic       last_result;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- src/two_button_gesture_recognizer_core.sv -----
// Channel  Dir  Word contents
// req      in   opcode, now_ms, pressed_bits
// rsp      out  gesture, debounced_bits, press_edges, last_result
// csr      in   index, wdata (always ready)
//
// An accepted word sits in the input register and is evaluated once the result
// queue has room; its results are written into that queue and presented from
// there. One word per cycle is sustained while the queue has room. Evaluation
// waits until the four-entry result queue has two free slots, so a word with two
// gestures is queued whole as two result words. Reset is synchronous and restores
// the register defaults, released levels and the idle episode.
`default_nettype none

module two_button_gesture_recognizer_core import tbgr_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_opcode,
   input  wire logic [NOW_WIDTH-1:0]     req_now_ms,
   input  wire logic [1:0]               req_pressed_bits,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [2:0]                    rsp_gesture,
   output logic [1:0]                    rsp_debounced_bits,
   output logic [1:0]                    rsp_press_edges,
   output logic                          rsp_last_result,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0]     csr_wdata
);

   cfg_type               cfg_ff, cfg_in;
   logic                  in_vld_ff, in_vld_in;
   logic [1:0]            op_ff;
   logic [NOW_WIDTH-1:0]  now_ff;
   logic [1:0]            lv_ff;
   logic                  room;
   logic                  fire;
   logic                  req_take;
   step_result_type       step;
   rsp_word_type          rsp_word;

   assign csr_ready = 1'b1;
   assign fire      = in_vld_ff && room;
   assign req_ready = !in_vld_ff || fire;
   assign req_take  = req_valid && req_ready;
   assign in_vld_in = req_take || (in_vld_ff && !fire);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DEBOUNCE:     cfg_in.debounce_time     = csr_wdata;
            REG_HOLD:         cfg_in.hold_time         = csr_wdata;
            REG_REPEAT_START: cfg_in.repeat_start_time = csr_wdata;
            REG_REPEAT_PER:   cfg_in.repeat_period     = csr_wdata;
            REG_LONG_CHORD:   cfg_in.long_chord_time   = csr_wdata;
            REG_CHORD_SKEW:   cfg_in.chord_skew_limit  = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time     <= DEBOUNCE_RST;
         cfg_ff.hold_time         <= HOLD_RST;
         cfg_ff.repeat_start_time <= REPEAT_START_RST;
         cfg_ff.repeat_period     <= REPEAT_PER_RST;
         cfg_ff.long_chord_time   <= LONG_CHORD_RST;
         cfg_ff.chord_skew_limit  <= CHORD_SKEW_RST;
         in_vld_ff                <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_opcode;
         now_ff <= req_now_ms;
         lv_ff  <= req_pressed_bits;
      end
   end

   tbgr_engine #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .cfg          (cfg_ff),
      .opcode       (op_ff),
      .now_ms       (now_ff),
      .pressed_bits (lv_ff),
      .result       (step)
   );

   tbgr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .step      (step),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_gesture        = rsp_word.gesture;
   assign rsp_debounced_bits = rsp_word.debounced_bits;
   assign rsp_press_edges    = rsp_word.press_edges;
   assign rsp_last_result    = rsp_word.last_result;

endmodule

`default_nettype wire

// ----- src/tbgr_engine.sv -----
`default_nettype none

module tbgr_engine import tbgr_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire cfg_type              cfg,
   input  wire logic [1:0]           opcode,
   input  wire logic [NOW_WIDTH-1:0] now_ms,
   input  wire logic [1:0]           pressed_bits,
   output step_result_type           result
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DOWN  = 3'd1;
   localparam logic [2:0] ST_HOLD  = 3'd2;
   localparam logic [2:0] ST_BOTH  = 3'd3;
   localparam logic [2:0] ST_MUTED = 3'd4;

   logic [2:0]            st_ff, st_in;
   logic                  act_ff, act_in;
   logic [1:0]            dl_ff, dl_in;
   logic [1:0]            rl_ff, rl_in;
   logic [TIME_WIDTH-1:0] rct_ff [2];
   logic [TIME_WIDTH-1:0] rct_in [2];
   logic [TIME_WIDTH-1:0] pt_ff [2];
   logic [TIME_WIDTH-1:0] pt_in [2];
   logic                  lcd_ff, lcd_in;
   logic [TIME_WIDTH-1:0] cst_ff, cst_in;
   logic [TIME_WIDTH-1:0] rbt_ff, rbt_in;

   logic [1:0] gcnt;
   logic [2:0] gs [2];
   logic [1:0] edg;

   always_comb begin : step
      logic                  bi;
      logic                  oth;
      logic                  p;
      logic [TIME_WIDTH-1:0] now_t;
      logic [TIME_WIDTH-1:0] t;
      logic [TIME_WIDTH-1:0] a;
      logic [TIME_WIDTH-1:0] skew;
      logic [2:0]            code;
      logic                  emit;

      st_in  = st_ff;
      act_in = act_ff;
      dl_in  = dl_ff;
      rl_in  = rl_ff;
      rct_in = rct_ff;
      pt_in  = pt_ff;
      lcd_in = lcd_ff;
      cst_in = cst_ff;
      rbt_in = rbt_ff;
      gcnt   = 2'd0;
      gs[0]  = G_NONE;
      gs[1]  = G_NONE;
      edg    = 2'b00;
      now_t  = TIME_WIDTH'(now_ms);
      bi     = 1'b0;
      oth    = 1'b1;
      p      = 1'b0;
      t      = '0;
      a      = '0;
      skew   = '0;
      code   = G_NONE;
      emit   = 1'b0;

      case (opcode)
         OP_SAMPLE: begin
            for (int b = 0; b < 2; b++) begin
               bi  = b[0];
               oth = ~bi;
               p   = pressed_bits[bi];
               if (p != rl_in[bi]) begin
                  rl_in[bi]  = p;
                  rct_in[bi] = now_t;
               end
               if ((p != dl_in[bi]) &&
                   ((now_t - rct_in[bi]) >= TIME_WIDTH'(cfg.debounce_time))) begin
                  dl_in[bi] = p;
                  if (p) begin
                     t          = rct_in[bi];
                     pt_in[bi]  = t;
                     edg[bi]    = 1'b1;
                     if (dl_in[oth]) begin
                        a    = pt_in[oth];
                        skew = (t >= a) ? (t - a) : (a - t);
                        if ((st_in == ST_DOWN) &&
                            (skew <= TIME_WIDTH'(cfg.chord_skew_limit))) begin
                           st_in  = ST_BOTH;
                           lcd_in = 1'b0;
                           cst_in = t;
                        end else begin
                           st_in = ST_MUTED;
                        end
                     end else begin
                        act_in = bi;
                        st_in  = ST_DOWN;
                     end
                  end else begin
                     emit = 1'b0;
                     code = G_NONE;
                     unique case (st_in)
                        ST_DOWN: begin
                           if (act_in == bi) begin
                              emit = 1'b1;
                              code = bi ? G_TAP_R : G_TAP_L;
                           end
                           st_in = dl_in[oth] ? ST_MUTED : ST_IDLE;
                        end
                        ST_HOLD: begin
                           st_in = dl_in[oth] ? ST_MUTED : ST_IDLE;
                        end
                        ST_BOTH: begin
                           if (!lcd_in) begin
                              emit = 1'b1;
                              code = G_CHORD;
                           end
                           st_in = dl_in[oth] ? ST_MUTED : ST_IDLE;
                        end
                        default: begin
                           if (dl_in == 2'b00) begin
                              st_in = ST_IDLE;
                           end
                        end
                     endcase
                     if (emit && (gcnt != 2'd2)) begin
                        gs[gcnt[0]] = code;
                        gcnt        = gcnt + 2'd1;
                     end
                  end
               end
            end

            emit = 1'b0;
            code = G_NONE;
            unique case (st_in)
               ST_DOWN: begin
                  if (rl_in[act_in] &&
                      ((now_t - pt_in[act_in]) >= TIME_WIDTH'(cfg.hold_time))) begin
                     emit   = 1'b1;
                     code   = act_in ? G_HOLD_R : G_HOLD_L;
                     st_in  = ST_HOLD;
                     rbt_in = pt_in[act_in] + TIME_WIDTH'(cfg.repeat_start_time);
                  end
               end
               ST_HOLD: begin
                  if (!act_in &&
                      ((now_t - rbt_in) >= TIME_WIDTH'(cfg.repeat_period))) begin
                     emit   = 1'b1;
                     code   = G_HOLD_L;
                     rbt_in = now_t;
                  end
               end
               ST_BOTH: begin
                  if (!lcd_in && rl_in[0] && rl_in[1] &&
                      ((now_t - cst_in) >= TIME_WIDTH'(cfg.long_chord_time))) begin
                     emit   = 1'b1;
                     code   = G_LONG;
                     lcd_in = 1'b1;
                  end
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
            if (emit && (gcnt != 2'd2)) begin
               gs[gcnt[0]] = code;
               gcnt        = gcnt + 2'd1;
            end
         end
         OP_FLUSH: begin
            st_in = (dl_in != 2'b00) ? ST_MUTED : ST_IDLE;
         end
         OP_RESTART: begin
            lcd_in    = 1'b0;
            cst_in    = now_t;
            rbt_in    = now_t;
            act_in    = 1'b0;
            rl_in     = pressed_bits;
            dl_in     = pressed_bits;
            rct_in[0] = now_t;
            rct_in[1] = now_t;
            pt_in[0]  = now_t;
            pt_in[1]  = now_t;
            st_in     = (pressed_bits != 2'b00) ? ST_MUTED : ST_IDLE;
         end
         default: begin
            st_in = st_ff;
         end
      endcase
   end

   always_comb begin
      result.two_results    = (gcnt == 2'd2);
      result.gesture0       = gs[0];
      result.gesture1       = gs[1];
      result.debounced_bits = dl_in;
      result.press_edges    = edg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         act_ff    <= 1'b0;
         dl_ff     <= 2'b00;
         rl_ff     <= 2'b00;
         rct_ff[0] <= '0;
         rct_ff[1] <= '0;
         pt_ff[0]  <= '0;
         pt_ff[1]  <= '0;
         lcd_ff    <= 1'b0;
         cst_ff    <= '0;
         rbt_ff    <= '0;
      end else if (fire) begin
         st_ff  <= st_in;
         act_ff <= act_in;
         dl_ff  <= dl_in;
         rl_ff  <= rl_in;
         rct_ff <= rct_in;
         pt_ff  <= pt_in;
         lcd_ff <= lcd_in;
         cst_ff <= cst_in;
         rbt_ff <= rbt_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/tbgr_rsp_fifo.sv -----
`default_nettype none

module tbgr_rsp_fifo import tbgr_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire step_result_type step,
   output logic                 room,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_word_type         rsp_word
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   rsp_word_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]             push_n;
   logic                   pop;
   rsp_word_type           w0;
   rsp_word_type           w1;

   assign room      = (cnt_ff <= CNT_W'(DEPTH - 2));
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_word  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign push_n    = push ? (step.two_results ? 2'd2 : 2'd1) : 2'd0;

   always_comb begin
      w0.gesture        = step.gesture0;
      w0.debounced_bits = step.debounced_bits;
      w0.press_edges    = step.press_edges;
      w0.last_result    = ~step.two_results;
      w1.gesture        = step.gesture1;
      w1.debounced_bits = step.debounced_bits;
      w1.press_edges    = step.press_edges;
      w1.last_result    = 1'b1;
      wr_ptr_in         = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in         = rd_ptr_ff + PTR_W'(pop);
      cnt_in            = cnt_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= w0;
         if (step.two_results) begin
            mem_ff[wr_ptr_ff + PTR_W'(1)] <= w1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/tbgr_checker.sv -----
`default_nettype none
`include "two_button_gesture_recognizer_core_assert.svh"

module tbgr_checker import tbgr_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_gesture,
   input wire logic [1:0] rsp_debounced_bits,
   input wire logic [1:0] rsp_press_edges,
   input wire logic       rsp_last_result
);

   // A stalled result word keeps its contents.
   `TBGR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_gesture) && $stable(rsp_debounced_bits) && $stable(rsp_press_edges) && $stable(rsp_last_result), "rsp word changed while stalled")

   // A button with a press edge in this word is debounced down afterwards.
   `TBGR_ASSERT_NOW(a_edge_down, rsp_valid, (rsp_press_edges & ~rsp_debounced_bits) == 2'b00, "press edge on a released button")

   // A tap fires on release, so the tapped button is debounced up.
   `TBGR_ASSERT_NOW(a_tap_up, rsp_valid && (rsp_gesture == G_TAP_L || rsp_gesture == G_TAP_R), (rsp_gesture == G_TAP_L) ? !rsp_debounced_bits[0] : !rsp_debounced_bits[1], "tap reported while button still down")

   // The second result of a word is queued together with the first.
   `TBGR_ASSERT_NEXT(a_second_ready, rsp_valid && rsp_ready && !rsp_last_result, rsp_valid, "missing final result of a word")

endmodule

bind two_button_gesture_recognizer_core tbgr_checker u_tbgr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_gesture        (rsp_gesture),
   .rsp_debounced_bits (rsp_debounced_bits),
   .rsp_press_edges    (rsp_press_edges),
   .rsp_last_result    (rsp_last_result)
);

`default_nettype wire
